// ----- hw/rtl/bra_pkg.sv -----
`default_nettype none
// ============================================================================
// bra_pkg
// Shared constants, codes and types of the next-fit bitmap range allocator.
// ============================================================================
package bra_pkg;

    localparam int MAP_ELEMENTS = 1024;
    localparam int WORD_BITS    = 32;
    localparam int WORD_COUNT   = (MAP_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int WORD_W       = $clog2(WORD_COUNT);
    localparam int ELEM_W       = $clog2(MAP_ELEMENTS);
    localparam int CNT_W        = ELEM_W + 1;
    localparam int ADDR_W       = 32;
    localparam int PADDR_W      = 3;

    localparam logic [WORD_BITS-1:0] WORD_ALL_USED = '1;

    // Status codes of a response.
    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    // Register indexes, taken from paddr[2].
    typedef enum logic {
        REG_BASE_ADDRESS    = 1'b0,
        REG_ELEMENTS_IN_USE = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_WORD_RD,
        S_WORD_CHK,
        S_SCAN,
        S_RUN_RD,
        S_RUN_EVAL,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [CNT_W-1:0]  elements_in_use;
    } cfg_t;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [WORD_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bra_if.sv -----
`default_nettype none
// ============================================================================
// bra_req_if / bra_rsp_if
// Valid/ready channels carrying allocation requests and their responses.
// ============================================================================
interface bra_req_if;
    logic                         valid;
    logic                         ready;
    logic [bra_pkg::CNT_W-1:0]    run_length;
    logic [bra_pkg::ADDR_W-1:0]   preferred_address;
    logic [bra_pkg::ADDR_W-1:0]   constraint_mask;
    logic                         commit;

    modport source (output valid, run_length, preferred_address, constraint_mask, commit,
                    input ready);
    modport sink   (input valid, run_length, preferred_address, constraint_mask, commit,
                    output ready);
endinterface

interface bra_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [bra_pkg::ELEM_W-1:0]   start_index;

    modport source (output valid, status, start_index, input ready);
    modport sink   (input valid, status, start_index, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bra_cfg.sv -----
`default_nettype none
// ============================================================================
// bra_cfg
// APB register file holding the base address and the managed element count.
// ============================================================================
module bra_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bra_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output bra_pkg::cfg_t                     cfg
);

    logic [bra_pkg::ADDR_W-1:0] base_reg;
    logic [bra_pkg::CNT_W-1:0]  elems_reg;
    bra_pkg::reg_index_t        sel;

    assign sel    = bra_pkg::reg_index_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            elems_reg <= bra_pkg::CNT_W'(bra_pkg::MAP_ELEMENTS);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                bra_pkg::REG_BASE_ADDRESS:    base_reg  <= pwdata;
                bra_pkg::REG_ELEMENTS_IN_USE: elems_reg <= pwdata[bra_pkg::CNT_W-1:0];
                default:                      base_reg  <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            bra_pkg::REG_BASE_ADDRESS:    prdata = base_reg;
            bra_pkg::REG_ELEMENTS_IN_USE: prdata = {{(32-bra_pkg::CNT_W){1'b0}}, elems_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.base_address    = base_reg;
    assign cfg.elements_in_use = elems_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bra_occ_mem.sv -----
`default_nettype none
// ============================================================================
// bra_occ_mem
// Occupancy word memory with registered read and per-word valid bits.
// ============================================================================
module bra_occ_mem (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bra_pkg::mem_req_t               req,
    output logic [bra_pkg::WORD_BITS-1:0]        rd_data
);

    logic [bra_pkg::WORD_BITS-1:0]  mem [bra_pkg::WORD_COUNT];
    logic [bra_pkg::WORD_COUNT-1:0] valid_reg;
    logic [bra_pkg::WORD_BITS-1:0]  rd_data_reg;

    // A word never written since reset reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (req.wr_en)
            valid_reg[req.wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bra_ctrl.sv -----
`default_nettype none
// ============================================================================
// bra_ctrl
// Search sequencer: word scan, per-bit candidate scan, run check and commit.
// ============================================================================
module bra_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bra_pkg::cfg_t               cfg,
    bra_req_if.sink                          req,
    bra_rsp_if.source                        rsp,
    output bra_pkg::mem_req_t                mem_req,
    input  wire logic [bra_pkg::WORD_BITS-1:0] mem_rd_data
);

    localparam int WB = bra_pkg::WORD_BITS;
    localparam int BW = bra_pkg::BIT_W;
    localparam int WW = bra_pkg::WORD_W;
    localparam int EW = bra_pkg::ELEM_W;
    localparam int CW = bra_pkg::CNT_W;

    bra_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]              len_reg, len_next;
    logic [31:0]                cons_reg, cons_next;
    logic                       commit_reg, commit_next;
    logic [WW-1:0]              w_reg, w_next;
    logic [WW:0]                i_reg, i_next;
    logic [BW:0]                b_reg, b_next;
    logic [WB-1:0]              word_reg, word_next;
    logic [CW-1:0]              run_reg, run_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [EW-1:0]              j_reg, j_next;
    logic [WW-1:0]              cw_reg, cw_next;
    logic [WW-1:0]              nf_reg, nf_next;
    bra_pkg::status_t           res_status_reg, res_status_next;
    logic [EW-1:0]              res_index_reg, res_index_next;
    logic                       out_valid_reg, out_valid_next;
    bra_pkg::status_t           out_status_reg, out_status_next;
    logic [EW-1:0]              out_index_reg, out_index_next;

    logic [CW-1:0]              elems;
    logic [WW+1:0]              words_wide;
    logic [WW:0]                words;
    logic [31:0]                pref_off;
    logic [WW-1:0]              pref_word;
    logic [EW-1:0]              j_scan;
    logic                       cons_hit;
    logic [CW-1:0]              need, rem, lim;
    logic [BW:0]                room, tz;
    logic [WB:0]                probe;
    logic [CW-1:0]              fail_run;
    logic [CW:0]                skip;
    logic [CW-1:0]              end_idx;
    logic [BW-1:0]              lo, hi;
    logic [WB-1:0]              mask;
    logic                       last_word;
    logic [WW-1:0]              w_inc;

    assign elems      = (cfg.elements_in_use > CW'(bra_pkg::MAP_ELEMENTS))
                        ? CW'(bra_pkg::MAP_ELEMENTS) : cfg.elements_in_use;
    assign words_wide = (WW+2)'((elems + CW'(WB - 1)) >> BW);
    assign words      = words_wide[WW:0];
    assign pref_off   = req.preferred_address - cfg.base_address;
    assign pref_word  = pref_off[BW +: WW];
    assign j_scan     = {w_reg, b_reg[BW-1:0]};
    assign cons_hit   = ((cfg.base_address + 32'(j_scan)) & cons_reg) != '0;
    assign last_word  = (i_reg + 1'b1) == words;
    assign w_inc      = ({1'b0, w_reg} + 1'b1 == words) ? '0 : w_reg + 1'b1;

    // Run check over the word holding pos: free bits from pos upward, with a
    // sentinel at the word end so the count stops there.
    assign need  = len_reg - run_reg;
    assign rem   = elems - pos_reg;
    assign lim   = (need < rem) ? need : rem;
    assign room  = (BW+1)'(WB) - {1'b0, pos_reg[BW-1:0]};
    assign probe = ({1'b0, mem_rd_data} >> pos_reg[BW-1:0]) | ((WB+1)'(1) << room);

    always_comb
    begin
        tz = (BW+1)'(WB);
        for (int k = WB; k >= 0; k--)
        begin
            if (probe[k])
                tz = (BW+1)'(k);
        end
    end

    // Commit mask for word cw_reg, covering j_reg .. j_reg + len - 1.
    assign end_idx = {1'b0, j_reg} + len_reg - 1'b1;
    assign lo      = (cw_reg == j_reg[EW-1 -: WW]) ? j_reg[BW-1:0] : '0;
    assign hi      = (cw_reg == end_idx[EW-1 -: WW]) ? end_idx[BW-1:0] : BW'(WB - 1);
    assign mask    = (bra_pkg::WORD_ALL_USED << lo)
                     & (bra_pkg::WORD_ALL_USED >> (BW'(WB - 1) - hi));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bra_pkg::S_IDLE;
            nf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        cons_reg       <= cons_next;
        commit_reg     <= commit_next;
        w_reg          <= w_next;
        i_reg          <= i_next;
        b_reg          <= b_next;
        word_reg       <= word_next;
        run_reg        <= run_next;
        pos_reg        <= pos_next;
        j_reg          <= j_next;
        cw_reg         <= cw_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cons_next       = cons_reg;
        commit_next     = commit_reg;
        w_next          = w_reg;
        i_next          = i_reg;
        b_next          = b_reg;
        word_next       = word_reg;
        run_next        = run_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        cw_next         = cw_reg;
        nf_next         = nf_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        fail_run        = '0;
        skip            = '0;
        mem_req         = '0;

        if (rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            bra_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    len_next        = req.run_length;
                    cons_next       = req.constraint_mask;
                    commit_next     = req.commit;
                    i_next          = '0;
                    res_index_next  = '0;
                    res_status_next = bra_pkg::STATUS_NOFIT;
                    w_next          = nf_reg;
                    if ((req.preferred_address > cfg.base_address) && (pref_off < 32'(elems))
                        && (pref_word > nf_reg))
                        w_next = pref_word;
                    if (req.run_length == '0)
                    begin
                        res_status_next = bra_pkg::STATUS_ZERO;
                        state_next      = bra_pkg::S_DONE;
                    end
                    else if (words == '0)
                        state_next = bra_pkg::S_DONE;
                    else
                        state_next = bra_pkg::S_NORM;
                end
            end
            bra_pkg::S_NORM:
            begin
                // A stale next-fit word wraps into the managed range.
                if ({1'b0, w_reg} >= words)
                    w_next = WW'({1'b0, w_reg} - words);
                else
                    state_next = bra_pkg::S_WORD_RD;
            end
            bra_pkg::S_WORD_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = w_reg;
                state_next      = bra_pkg::S_WORD_CHK;
            end
            bra_pkg::S_WORD_CHK:
            begin
                word_next = mem_rd_data;
                b_next    = '0;
                if (mem_rd_data == bra_pkg::WORD_ALL_USED)
                begin
                    if (last_word)
                        state_next = bra_pkg::S_DONE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        w_next     = w_inc;
                        state_next = bra_pkg::S_WORD_RD;
                    end
                end
                else
                    state_next = bra_pkg::S_SCAN;
            end
            bra_pkg::S_SCAN:
            begin
                if (b_reg[BW] || ({1'b0, j_scan} >= elems))
                begin
                    if (last_word)
                        state_next = bra_pkg::S_DONE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        w_next     = w_inc;
                        state_next = bra_pkg::S_WORD_RD;
                    end
                end
                else if (cons_hit || word_reg[b_reg[BW-1:0]])
                    b_next = b_reg + 1'b1;
                else
                begin
                    j_next     = j_scan;
                    run_next   = CW'(1);
                    pos_next   = {1'b0, j_scan} + 1'b1;
                    state_next = bra_pkg::S_RUN_RD;
                end
            end
            bra_pkg::S_RUN_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos_reg[EW-1 -: WW];
                state_next      = bra_pkg::S_RUN_EVAL;
            end
            bra_pkg::S_RUN_EVAL:
            begin
                if (CW'(tz) >= lim)
                begin
                    if (run_reg + lim == len_reg)
                    begin
                        res_status_next = bra_pkg::STATUS_FOUND;
                        res_index_next  = j_reg;
                        if (commit_reg)
                        begin
                            nf_next    = w_reg;
                            cw_next    = j_reg[EW-1 -: WW];
                            state_next = bra_pkg::S_COMMIT_RD;
                        end
                        else
                            state_next = bra_pkg::S_DONE;
                    end
                    else
                        fail_run = run_reg + lim;
                end
                else if (tz < room)
                    fail_run = run_reg + CW'(tz);
                else
                begin
                    run_next   = run_reg + CW'(tz);
                    pos_next   = pos_reg + CW'(tz);
                    state_next = bra_pkg::S_RUN_RD;
                end
                // A failed run moves the next candidate past the obstacle.
                if (fail_run != '0)
                begin
                    skip       = (CW+1)'(b_reg) + (CW+1)'(fail_run) + 1'b1;
                    b_next     = (skip >= (CW+1)'(WB)) ? (BW+1)'(WB) : skip[BW:0];
                    state_next = bra_pkg::S_SCAN;
                end
            end
            bra_pkg::S_COMMIT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cw_reg;
                state_next      = bra_pkg::S_COMMIT_WR;
            end
            bra_pkg::S_COMMIT_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cw_reg;
                mem_req.wr_data = mem_rd_data | mask;
                if (cw_reg == end_idx[EW-1 -: WW])
                    state_next = bra_pkg::S_DONE;
                else
                begin
                    cw_next    = cw_reg + 1'b1;
                    state_next = bra_pkg::S_COMMIT_RD;
                end
            end
            bra_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = bra_pkg::S_IDLE;
                end
            end
            default:
                state_next = bra_pkg::S_IDLE;
        endcase
    end

    assign req.ready       = (state_reg == bra_pkg::S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.start_index = out_index_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_range_allocator_top.sv -----
`default_nettype none
// ============================================================================
// bitmap_range_allocator_top
// Next-fit bitmap range allocator over a 1024-element occupancy bitmap.
// ============================================================================
//
//   Channel   Kind           Transaction content
//   --------  -------------  ------------------------------------------------
//   req       valid/ready    run_length, preferred_address, constraint_mask,
//                            commit
//   rsp       valid/ready    status, start_index
//   APB       psel/penable   base_address (0x0), elements_in_use (0x4)
//
// One request is worked on at a time; req.ready is high only while idle.
// A request passes through these steps: settling the start word (once more
// per wrap of a stale next-fit word), a read of each occupancy word visited,
// a test of each candidate bit examined plus a step to leave a word, a read
// of each word covered by a run check, a read and a write of each word marked
// on commit, and loading the response. A zero-length request, or one with no
// managed element, goes from acceptance straight to loading its response; a
// search, by contrast, may try every bit of all 32 words.
// The occupancy memory has one read and one write port with registered read
// data, so every word read has an address state followed by a data state.
// Reset clears the control state and the per-word valid bits of the memory,
// so the bitmap reads as all free at once; no clearing pass is needed.
// The response sits in an output register; once it has been loaded the block
// is idle again and takes the next request while the response waits. A later
// response that finds the register still full holds the block in its last
// cycle until the waiting transaction is taken.
//
// The scan starts at the later of the next-fit word and the word holding the
// preferred address, visits the managed words with wraparound and skips full
// words. Within a word, candidates are tried one bit per cycle between run
// checks: the start address must clear the constraint mask and the element
// must be free; then the run is checked word by word, into later words too.
//
module bitmap_range_allocator_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bra_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    bra_req_if.sink                           req,
    bra_rsp_if.source                         rsp
);

    bra_pkg::cfg_t                  cfg;
    bra_pkg::mem_req_t              mem_req;
    logic [bra_pkg::WORD_BITS-1:0]  mem_rd_data;

    // Registers; user writes only while no request is in flight, unenforced.
    bra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Search and commit sequencer, which owns the next-fit pointer.
    bra_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // Occupancy bitmap, one word per entry.
    bra_occ_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/bra_checker.sv -----
`default_nettype none
// ============================================================================
// bra_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
module bra_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pready,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [1:0]                    rsp_status,
    input wire logic [bra_pkg::ELEM_W-1:0]    rsp_start_index
);

    // A stalled response keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_start_index))
        else $error("response changed while stalled");

    // Failures and zero-length requests report index zero.
    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != bra_pkg::STATUS_FOUND) |-> rsp_start_index == '0)
        else $error("failed response carries a nonzero index");

    // One request at a time: the block is busy right after taking one.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another was in flight");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("APB pready dropped");

endmodule

bind bitmap_range_allocator_top bra_checker u_bra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_start_index (rsp.start_index)
);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for bitmap_range_allocator_top
// Sends allocation requests and predicts each response with a model of the
// occupancy bitmap, the next-fit word and the two configuration registers.
// The run has a directed part and random parts under several configurations.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [bra_pkg::CNT_W-1:0]  run_length;
        logic [bra_pkg::ADDR_W-1:0] preferred_address;
        logic [bra_pkg::ADDR_W-1:0] constraint_mask;
        logic                       commit;
    } alloc_req_t;

    typedef struct {
        bra_pkg::status_t           status;
        logic [bra_pkg::ELEM_W-1:0] start_index;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bra_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    bra_req_if req ();
    bra_rsp_if rsp ();

    bitmap_range_allocator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .rsp     (rsp.source)
    );

    // Model of the allocator state and of its registers.
    logic [bra_pkg::WORD_BITS-1:0] occ_words [bra_pkg::WORD_COUNT];
    int                            nf_word_model;
    logic [bra_pkg::ADDR_W-1:0]    cfg_base;
    logic [bra_pkg::CNT_W-1:0]     cfg_elements;

    alloc_req_t pending_reqs [$];
    alloc_rsp_t awaited_rsps [$];

    // Idle percentages of the two sides, changed only between phases.
    int send_idle;
    int recv_idle;

    int errors;
    int n_reqs;
    int n_rsps;
    int n_found;
    int n_nofit;
    int n_zero;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    localparam int WATCHDOG_LIMIT = 200000;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit elem_used(int idx);
        if (idx >= bra_pkg::MAP_ELEMENTS)
            return 1'b1;
        return occ_words[idx / bra_pkg::WORD_BITS][idx % bra_pkg::WORD_BITS];
    endfunction

    // Works out the response to one request and applies a commit to the model.
    function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
        alloc_rsp_t                 res;
        int                         elems;
        int                         words;
        int                         start;
        int                         w;
        int                         bit_i;
        int                         j;
        int                         run;
        int                         len;
        logic [bra_pkg::ADDR_W-1:0] off;
        logic [bra_pkg::ADDR_W-1:0] addr;
        res.status      = bra_pkg::STATUS_NOFIT;
        res.start_index = '0;
        len = int'(r.run_length);
        if (len == 0)
        begin
            res.status = bra_pkg::STATUS_ZERO;
            return res;
        end
        elems = (cfg_elements > bra_pkg::MAP_ELEMENTS) ? bra_pkg::MAP_ELEMENTS
                                                       : int'(cfg_elements);
        words = (elems + bra_pkg::WORD_BITS - 1) / bra_pkg::WORD_BITS;
        if (words == 0)
            return res;
        start = nf_word_model;
        if (r.preferred_address > cfg_base)
        begin
            off = r.preferred_address - cfg_base;
            if (off < elems && int'(off / bra_pkg::WORD_BITS) > start)
                start = int'(off / bra_pkg::WORD_BITS);
        end
        for (int i = 0; i < words; i++)
        begin
            w = (start + i) % words;
            if (occ_words[w] == bra_pkg::WORD_ALL_USED)
                continue;
            bit_i = 0;
            while (bit_i < bra_pkg::WORD_BITS)
            begin
                j = w * bra_pkg::WORD_BITS + bit_i;
                if (j >= elems)
                    break;
                addr = cfg_base + bra_pkg::ADDR_W'(j);
                if ((addr & r.constraint_mask) != 0 || elem_used(j))
                begin
                    bit_i++;
                    continue;
                end
                run = 1;
                while (run < len && j + run < elems && !elem_used(j + run))
                    run++;
                if (run == len)
                begin
                    if (r.commit)
                    begin
                        for (int k = 0; k < len; k++)
                            occ_words[(j + k) / bra_pkg::WORD_BITS]
                                     [(j + k) % bra_pkg::WORD_BITS] = 1'b1;
                        nf_word_model = w;
                    end
                    res.status      = bra_pkg::STATUS_FOUND;
                    res.start_index = bra_pkg::ELEM_W'(j);
                    return res;
                end
                // Every start inside the failed run hits the same used element.
                bit_i += run + 1;
            end
        end
        return res;
    endfunction

    // Request driver: takes the next pending request unless it idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid             <= 1'b0;
            req.run_length        <= '0;
            req.preferred_address <= '0;
            req.constraint_mask   <= '0;
            req.commit            <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                alloc_req_t cur;
                cur.run_length        = req.run_length;
                cur.preferred_address = req.preferred_address;
                cur.constraint_mask   = req.constraint_mask;
                cur.commit            = req.commit;
                awaited_rsps.push_back(predict_alloc(cur));
                n_reqs++;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    alloc_req_t nxt;
                    nxt = pending_reqs.pop_front();
                    req.valid             <= 1'b1;
                    req.run_length        <= nxt.run_length;
                    req.preferred_address <= nxt.preferred_address;
                    req.constraint_mask   <= nxt.constraint_mask;
                    req.commit            <= nxt.commit;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each transaction against the oldest expectation
    // and drives ready, including one long hold-off that fills the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                alloc_rsp_t want;
                n_rsps++;
                if (awaited_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response status=%0d start_index=%0d",
                             $realtime, rsp.status, rsp.start_index);
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $realtime, want.status, rsp.status);
                    end
                    if (rsp.start_index !== want.start_index)
                    begin
                        errors++;
                        $display("%0t: start_index mismatch expected %0d actual %0d",
                                 $realtime, want.start_index, rsp.start_index);
                    end
                    case (want.status)
                        bra_pkg::STATUS_FOUND: n_found++;
                        bra_pkg::STATUS_NOFIT: n_nofit++;
                        default:               n_zero++;
                    endcase
                end
            end
            if (!hold_done && n_rsps == 80)
            begin
                hold_left <= 600;
                hold_done <= 1'b1;
                rsp.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(bra_pkg::reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bra_pkg::PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == bra_pkg::REG_BASE_ADDRESS)
            cfg_base = value;
        else
            cfg_elements = value[bra_pkg::CNT_W-1:0];
    endtask

    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_reqs.size() > 0 || req.valid || awaited_rsps.size() > 0);
        // Every accepted request has been answered here; idle a while before the next phase.
        repeat (20) @(negedge clk);
    endtask

    task automatic queue_req(int len, logic [31:0] pref, logic [31:0] mask, bit cmt);
        alloc_req_t r;
        r.run_length        = bra_pkg::CNT_W'(len);
        r.preferred_address = pref;
        r.constraint_mask   = mask;
        r.commit            = cmt;
        pending_reqs.push_back(r);
    endtask

    // Random request: mostly short runs near the managed range, with some
    // long runs, alignment masks and fully random fields mixed in.
    task automatic queue_random(int count);
        int          len;
        int          pick;
        logic [31:0] pref;
        logic [31:0] mask;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                len = $urandom_range(1, 6);
            else if (pick < 85)
                len = $urandom_range(7, 48);
            else if (pick < 90)
                len = 0;
            else if (pick < 95)
                len = 1024;
            else
                len = $urandom_range(0, 1024);
            if ($urandom_range(1))
                pref = cfg_base + $urandom_range(0, 1100);
            else
                pref = $urandom;
            pick = $urandom_range(9);
            if (pick < 6)
                mask = 0;
            else if (pick < 9)
                mask = (32'd1 << $urandom_range(0, 5)) - 1;
            else
                mask = $urandom;
            queue_req(len, pref, mask, $urandom_range(99) < 30);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors = 0; n_reqs = 0; n_rsps = 0;
        n_found = 0; n_nofit = 0; n_zero = 0;
        idle_cycles = 0;
        for (int w = 0; w < bra_pkg::WORD_COUNT; w++)
            occ_words[w] = '0;
        nf_word_model = 0;
        cfg_base      = '0;
        cfg_elements  = bra_pkg::CNT_W'(bra_pkg::MAP_ELEMENTS);
        send_idle = 12;
        recv_idle = 54;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset configuration.
        queue_req(0, 0, 0, 1);
        queue_req(1024, 0, 0, 0);
        queue_req(1, 0, 32'hFFFF_FFFF, 1);
        queue_req(1, 0, 32'hFFFF_FFFF, 0);
        queue_req(1024, 0, 0, 0);
        queue_req(3, 0, 0, 1);
        queue_req(5, 500, 0, 1);
        queue_req(4, 1023, 0, 0);
        queue_req(2, 1024, 0, 0);
        queue_req(40, 60, 0, 1);
        queue_req(8, 0, 32'h7, 1);
        queue_req(1, 32'hFFFF_FFFF, 0, 0);
        queue_req(31, 0, 32'h1F, 1);
        queue_req(1, 0, 32'h200, 0);
        queue_req(64, 0, 32'h1F, 1);
        queue_req(32, 990, 0, 1);
        queue_req(1, 990, 0, 0);
        queue_req(600, 0, 0, 0);
        queue_req(1023, 0, 0, 0);
        drain_all();

        // Random requests with a shifted base; the long hold-off falls here.
        write_reg(bra_pkg::REG_BASE_ADDRESS, 32'h0000_1000);
        queue_random(180);
        drain_all();

        // Base near the top of the address space and a reduced element
        // count, which leaves the next-fit word beyond the managed words.
        send_idle = 54;
        recv_idle = 12;
        write_reg(bra_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFF0);
        write_reg(bra_pkg::REG_ELEMENTS_IN_USE, 32'd100);
        queue_random(150);
        drain_all();

        // No managed element at all.
        send_idle = 0;
        recv_idle = 0;
        write_reg(bra_pkg::REG_ELEMENTS_IN_USE, 32'd0);
        queue_req(0, 0, 0, 1);
        queue_req(1, 0, 0, 1);
        queue_req(1024, 32'hFFFF_FFFF, 0, 0);
        queue_req(7, 5, 32'hFFFF_FFFF, 1);
        drain_all();

        // Element count above the bitmap size, random base.
        write_reg(bra_pkg::REG_ELEMENTS_IN_USE, 32'd2047);
        write_reg(bra_pkg::REG_BASE_ADDRESS, $urandom);
        queue_random(170);
        drain_all();

        // A single managed element.
        write_reg(bra_pkg::REG_BASE_ADDRESS, 32'd0);
        write_reg(bra_pkg::REG_ELEMENTS_IN_USE, 32'd1);
        queue_random(30);
        drain_all();

        repeat (200) @(negedge clk);
        $display("Covered %0d requests over six register settings: %0d found, %0d no fit,",
                 n_reqs, n_found, n_nofit);
        $display("%0d zero length, including a long response stall and element counts 0..2047.",
                 n_zero);
        if (errors == 0 && awaited_rsps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
